// File: sv/npi_pkg.sv
// Package for the Newton piecewise interpolator: opcodes, status codes,
// register indexes, the point store depth and the sequencer state type. No dependencies.
`timescale 1ns / 1ps

package npi_pkg;

    // The point_index port and the point_count register are sized for this depth.
    localparam int MAX_POINTS = 64;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_BUILD = 2'd1,
        OP_EVAL  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_WIN  = 2'd1,
        ST_RANGE    = 2'd2,
        ST_NO_BUILD = 2'd3
    } status_t;

    localparam logic REG_WINDOW_SIZE = 1'b0;
    localparam logic REG_POINT_COUNT = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_EV_CHECK0,
        S_EV_CHECK1,
        S_EV_SCAN,
        S_EV_SCAN_W,
        S_EV_CRD,
        S_EV_CRD_W,
        S_EV_XRD,
        S_EV_XRD_W,
        S_EV_MUL,
        S_EV_ADD,
        S_BD_YRD,
        S_BD_YRD_W,
        S_BD_XRD,
        S_BD_XRD_W,
        S_BD_DIV,
        S_BD_DIVRUN,
        S_BD_STORE,
        S_DONE
    } state_t;

endpackage

// File: sv/newton_piecewise_interpolator_unit.sv
// Top level of the Newton piecewise interpolator: point and coefficient
// memories, a sequencer and one shared multiplier and serial divider.
// Depends on npi_pkg.
`timescale 1ns / 1ps

// Usage:
// A request is taken when start is high and busy is low. op selects load
// point (point_index, x_value, y_value), build coefficients, or evaluate at
// the query x_value. A load or an unused op gives no result and busy stays
// low, so the next request can be taken at the following edge. A build or an
// evaluate raises busy and gives exactly one result on y_result and status,
// marked by done for one cycle in which busy is already low again.
// An evaluate with a bad window or no build goes straight to the done state,
// one out of range after the reads of the first and last point. A full
// evaluate scans each point from w/2 up with a read and a compare state, then
// runs a Horner step per order (point read, multiply, shift, coefficient
// add) on the shared multiplier. A build reads the w ordinates of each window
// start, then runs w*(w-1)/2 divides for it, each with operand reads and 50
// restoring steps (none when the spacing is zero; the quotient saturates).
// The receiver cannot stall, so each result is presented once. Reset sets
// window_size 3 and point_count 0 and marks the coefficients as not built;
// the memories are not cleared and must be loaded before use.
// Configuration must be written through the APB port while the block is idle;
// the block itself does not enforce this.
module newton_piecewise_interpolator_unit #(
    parameter int MAX_WINDOW = 8,
    parameter int FRAC_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [5:0]  point_index,
    input  logic signed [31:0] x_value,
    input  logic signed [31:0] y_value,
    output logic        done,
    output logic signed [31:0] y_result,
    output logic [1:0]  status
);

    localparam int PW  = $clog2(npi_pkg::MAX_POINTS);
    localparam int WW  = $clog2(MAX_WINDOW);
    localparam int CW  = PW + WW;
    localparam int NW  = PW + 1;
    localparam int DW  = 32 + FRAC_BITS + 2;   // divider width
    localparam int DCW = $clog2(DW + 1);
    localparam logic signed [63:0] MAXV = 64'sd2147483647;
    localparam logic signed [63:0] MINV = -64'sd2147483648;

    // Configuration registers.
    logic [3:0] window_size_reg;
    logic [6:0] point_count_reg;
    logic       built_reg;

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == npi_pkg::REG_WINDOW_SIZE) prdata = {28'd0, window_size_reg};
        else prdata = {25'd0, point_count_reg};
    end

    // Memories.
    logic signed [31:0] px_mem [npi_pkg::MAX_POINTS];
    logic signed [31:0] py_mem [npi_pkg::MAX_POINTS];
    logic signed [31:0] cf_mem [2**CW];
    logic [PW-1:0] p_raddr;
    logic signed [31:0] px_rd_reg, py_rd_reg, cf_rd_reg;
    logic [CW-1:0] c_raddr, c_waddr;
    logic          c_we;
    logic signed [31:0] c_wdata;

    // Derived configuration.
    logic [NW-1:0] n_used;
    logic          win_ok;
    logic [WW:0]   w;
    always_comb
    begin
        n_used = (point_count_reg > 7'(npi_pkg::MAX_POINTS)) ? NW'(npi_pkg::MAX_POINTS)
                                                             : NW'(point_count_reg);
        w = (WW+1)'(window_size_reg);
        win_ok = (window_size_reg >= 4'd2)
              && ({3'd0, window_size_reg} <= 7'(MAX_WINDOW))
              && ({3'd0, window_size_reg} + 7'd2 <= 7'(n_used));
    end

    // Sequencer registers.
    npi_pkg::state_t state_reg, state_next;
    logic signed [31:0] q_reg, q_next;
    logic [NW-1:0] i_reg, i_next;      // scan index
    logic [NW-1:0] k_reg, k_next;      // count or window start
    logic [WW:0]   t_reg, t_next;      // Horner index / order j
    logic [WW:0]   m_reg, m_next;      // inner index i
    logic signed [31:0] r_reg, r_next;
    logic signed [63:0] prod_reg, prod_next;
    logic signed [31:0] dd_reg [MAX_WINDOW];
    logic signed [31:0] dd_next [MAX_WINDOW];
    logic signed [31:0] xa_reg, xa_next;
    logic [1:0] st_reg, st_next;
    logic signed [31:0] res_reg, res_next;
    logic done_reg, done_next;
    logic built_next;

    // Serial divider registers.
    logic [DW-1:0] dv_num_reg, dv_num_next;
    logic [DW-1:0] dv_rem_reg, dv_rem_next;
    logic [DW-1:0] dv_den_reg, dv_den_next;
    logic          dv_neg_reg, dv_neg_next;
    logic [DCW-1:0] dv_cnt_reg, dv_cnt_next;

    assign busy     = (state_reg != npi_pkg::S_IDLE);
    assign done     = done_reg;
    assign y_result = res_reg;
    assign status   = st_reg;

    logic accept;
    assign accept = start && !busy;

    always_ff @(posedge clk)
    begin
        if (accept && op == npi_pkg::OP_LOAD
            && 7'(point_index) < 7'(npi_pkg::MAX_POINTS))
        begin
            px_mem[PW'(point_index)] <= x_value;
            py_mem[PW'(point_index)] <= y_value;
        end
        px_rd_reg <= px_mem[p_raddr];
        py_rd_reg <= py_mem[p_raddr];
        if (c_we) cf_mem[c_waddr] <= c_wdata;
        cf_rd_reg <= cf_mem[c_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= 4'd3;
            point_count_reg <= 7'd0;
            built_reg       <= 1'b0;
            state_reg       <= npi_pkg::S_IDLE;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            built_reg <= built_next;
            if (cfg_wr)
            begin
                if (paddr[2] == npi_pkg::REG_WINDOW_SIZE) window_size_reg <= pwdata[3:0];
                else point_count_reg <= pwdata[6:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;  i_reg <= i_next;  k_reg <= k_next;
        t_reg <= t_next;  m_reg <= m_next;  r_reg <= r_next;
        prod_reg <= prod_next;  xa_reg <= xa_next;
        st_reg <= st_next;  res_reg <= res_next;
        dv_num_reg <= dv_num_next;  dv_rem_reg <= dv_rem_next;
        dv_den_reg <= dv_den_next;  dv_neg_reg <= dv_neg_next;
        dv_cnt_reg <= dv_cnt_next;
        for (int e = 0; e < MAX_WINDOW; e++) dd_reg[e] <= dd_next[e];
    end

    function automatic logic signed [31:0] sat(input logic signed [63:0] v);
        if (v > MAXV) return 32'sh7fffffff;
        if (v < MINV) return 32'sh80000000;
        return v[31:0];
    endfunction

    // Combinational helpers.
    logic signed [63:0] diff64, sum64, num64, den64, quo64;
    logic [DW-1:0] dv_try;
    logic [DW-1:0] dv_shift;

    always_comb
    begin
        state_next = state_reg;
        q_next = q_reg;  i_next = i_reg;  k_next = k_reg;
        t_next = t_reg;  m_next = m_reg;  r_next = r_reg;
        prod_next = prod_reg;  xa_next = xa_reg;
        st_next = st_reg;  res_next = res_reg;
        done_next = 1'b0;
        built_next = built_reg;
        dv_num_next = dv_num_reg;  dv_rem_next = dv_rem_reg;
        dv_den_next = dv_den_reg;  dv_neg_next = dv_neg_reg;
        dv_cnt_next = dv_cnt_reg;
        for (int e = 0; e < MAX_WINDOW; e++) dd_next[e] = dd_reg[e];
        p_raddr = '0;
        c_raddr = '0;
        c_we = 1'b0;
        c_waddr = '0;
        c_wdata = '0;
        diff64 = '0;  sum64 = '0;  num64 = '0;  den64 = '0;  quo64 = '0;
        dv_shift = '0;  dv_try = '0;

        if (cfg_wr) built_next = 1'b0;

        unique case (state_reg)
            npi_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    q_next = x_value;
                    res_next = '0;
                    unique case (op)
                        npi_pkg::OP_LOAD:
                        begin
                            built_next = 1'b0;
                        end
                        npi_pkg::OP_BUILD:
                        begin
                            if (!win_ok)
                            begin
                                built_next = 1'b0;
                                st_next = npi_pkg::ST_BAD_WIN;
                                state_next = npi_pkg::S_DONE;
                            end
                            else
                            begin
                                st_next = npi_pkg::ST_OK;
                                k_next = '0;
                                m_next = '0;
                                state_next = npi_pkg::S_BD_YRD;
                            end
                        end
                        npi_pkg::OP_EVAL:
                        begin
                            if (!win_ok)
                            begin
                                st_next = npi_pkg::ST_BAD_WIN;
                                state_next = npi_pkg::S_DONE;
                            end
                            else if (!built_reg)
                            begin
                                st_next = npi_pkg::ST_NO_BUILD;
                                state_next = npi_pkg::S_DONE;
                            end
                            else
                            begin
                                st_next = npi_pkg::ST_OK;
                                state_next = npi_pkg::S_EV_CHECK0;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // Range check against the first and last point.
            npi_pkg::S_EV_CHECK0:
            begin
                p_raddr = '0;
                state_next = npi_pkg::S_EV_CHECK1;
            end
            npi_pkg::S_EV_CHECK1:
            begin
                p_raddr = PW'(n_used - 1'b1);
                xa_next = px_rd_reg;
                state_next = npi_pkg::S_EV_SCAN;
            end
            npi_pkg::S_EV_SCAN:
            begin
                // px_rd_reg now holds the last point.
                if (q_reg < xa_reg || q_reg > px_rd_reg)
                begin
                    st_next = npi_pkg::ST_RANGE;
                    state_next = npi_pkg::S_DONE;
                end
                else
                begin
                    i_next = NW'(w >> 1);
                    k_next = '0;
                    state_next = npi_pkg::S_EV_SCAN_W;
                end
            end
            npi_pkg::S_EV_SCAN_W:
            begin
                // Count points from w/2 upward that lie below the query.
                if (i_reg >= n_used)
                begin
                    if (k_reg > n_used - NW'(w)) k_next = n_used - NW'(w);
                    t_next = w - 1'b1;
                    state_next = npi_pkg::S_EV_CRD;
                end
                else
                begin
                    p_raddr = PW'(i_reg);
                    state_next = npi_pkg::S_EV_CRD_W;
                end
            end
            npi_pkg::S_EV_CRD_W:
            begin
                if (px_rd_reg < q_reg) k_next = k_reg + 1'b1;
                i_next = i_reg + 1'b1;
                state_next = npi_pkg::S_EV_SCAN_W;
            end
            npi_pkg::S_EV_CRD:
            begin
                c_raddr = {PW'(k_reg), WW'(t_reg)};
                state_next = npi_pkg::S_EV_XRD;
            end
            npi_pkg::S_EV_XRD:
            begin
                // The shifted product is added at full width before saturation.
                sum64 = 64'(cf_rd_reg);
                if (t_reg != w - 1'b1) sum64 = prod_reg + 64'(cf_rd_reg);
                r_next = sat(sum64);
                if (t_reg == '0)
                begin
                    res_next = sat(sum64);
                    state_next = npi_pkg::S_DONE;
                end
                else
                begin
                    t_next = t_reg - 1'b1;
                    state_next = npi_pkg::S_EV_XRD_W;
                end
            end
            npi_pkg::S_EV_XRD_W:
            begin
                p_raddr = PW'(k_reg + NW'(t_reg));
                state_next = npi_pkg::S_EV_MUL;
            end
            npi_pkg::S_EV_MUL:
            begin
                diff64 = 64'(q_reg) - 64'(px_rd_reg);
                prod_next = 64'(r_reg) * 64'(sat(diff64));
                state_next = npi_pkg::S_EV_ADD;
            end
            npi_pkg::S_EV_ADD:
            begin
                // Arithmetic shift floors; the coefficient add follows.
                prod_next = prod_reg >>> FRAC_BITS;
                c_raddr = {PW'(k_reg), WW'(t_reg)};
                state_next = npi_pkg::S_EV_XRD;
            end

            // Build: load y of the window, then triangle of divides.
            npi_pkg::S_BD_YRD:
            begin
                p_raddr = PW'(k_reg + NW'(m_reg));
                state_next = npi_pkg::S_BD_YRD_W;
            end
            npi_pkg::S_BD_YRD_W:
            begin
                for (int e = 0; e < MAX_WINDOW; e++)
                    if (WW'(e) == WW'(m_reg)) dd_next[e] = py_rd_reg;
                if (m_reg == '0)
                begin
                    c_we = 1'b1;
                    c_waddr = {PW'(k_reg), WW'(0)};
                    c_wdata = py_rd_reg;
                end
                if (m_reg == w - 1'b1)
                begin
                    t_next = (WW+1)'(1);
                    m_next = '0;
                    state_next = npi_pkg::S_BD_XRD;
                end
                else
                begin
                    m_next = m_reg + 1'b1;
                    state_next = npi_pkg::S_BD_YRD;
                end
            end
            npi_pkg::S_BD_XRD:
            begin
                p_raddr = PW'(k_reg + NW'(m_reg));
                state_next = npi_pkg::S_BD_XRD_W;
            end
            npi_pkg::S_BD_XRD_W:
            begin
                xa_next = px_rd_reg;
                p_raddr = PW'(k_reg + NW'(m_reg) + NW'(t_reg));
                state_next = npi_pkg::S_BD_DIV;
            end
            npi_pkg::S_BD_DIV:
            begin
                num64 = 64'(dd_reg[WW'(m_reg + 1'b1)]) - 64'(dd_reg[WW'(m_reg)]);
                den64 = 64'(px_rd_reg) - 64'(xa_reg);
                if (den64 == 0)
                begin
                    for (int e = 0; e < MAX_WINDOW; e++)
                        if (WW'(e) == WW'(m_reg))
                            dd_next[e] = (num64 > 0) ? 32'sh7fffffff :
                                         (num64 < 0) ? 32'sh80000000 : 32'sd0;
                    state_next = npi_pkg::S_BD_STORE;
                end
                else
                begin
                    dv_neg_next = num64[63] ^ den64[63];
                    dv_num_next = DW'((num64[63] ? -num64 : num64) << FRAC_BITS);
                    dv_den_next = DW'(den64[63] ? -den64 : den64);
                    dv_rem_next = '0;
                    dv_cnt_next = DCW'(DW);
                    state_next = npi_pkg::S_BD_DIVRUN;
                end
            end
            npi_pkg::S_BD_DIVRUN:
            begin
                // One restoring division step per cycle.
                dv_shift = {dv_rem_reg[DW-2:0], dv_num_reg[DW-1]};
                if (dv_shift >= dv_den_reg)
                begin
                    dv_try = dv_shift - dv_den_reg;
                    dv_num_next = {dv_num_reg[DW-2:0], 1'b1};
                end
                else
                begin
                    dv_try = dv_shift;
                    dv_num_next = {dv_num_reg[DW-2:0], 1'b0};
                end
                dv_rem_next = dv_try;
                dv_cnt_next = dv_cnt_reg - 1'b1;
                if (dv_cnt_reg == DCW'(1))
                begin
                    quo64 = 64'(dv_num_next);
                    if (dv_neg_reg) quo64 = -quo64;
                    for (int e = 0; e < MAX_WINDOW; e++)
                        if (WW'(e) == WW'(m_reg)) dd_next[e] = sat(quo64);
                    state_next = npi_pkg::S_BD_STORE;
                end
            end
            npi_pkg::S_BD_STORE:
            begin
                if (m_reg + t_reg == w - 1'b1)
                begin
                    c_we = 1'b1;
                    c_waddr = {PW'(k_reg), WW'(t_reg)};
                    c_wdata = dd_reg[0];
                    if (t_reg == w - 1'b1)
                    begin
                        if (k_reg == n_used - NW'(w))
                        begin
                            built_next = 1'b1;
                            state_next = npi_pkg::S_DONE;
                        end
                        else
                        begin
                            k_next = k_reg + 1'b1;
                            m_next = '0;
                            state_next = npi_pkg::S_BD_YRD;
                        end
                    end
                    else
                    begin
                        t_next = t_reg + 1'b1;
                        m_next = '0;
                        state_next = npi_pkg::S_BD_XRD;
                    end
                end
                else
                begin
                    m_next = m_reg + 1'b1;
                    state_next = npi_pkg::S_BD_XRD;
                end
            end

            npi_pkg::S_DONE:
            begin
                if (st_reg != npi_pkg::ST_OK) res_next = '0;
                done_next = 1'b1;
                state_next = npi_pkg::S_IDLE;
            end
            default: state_next = npi_pkg::S_IDLE;
        endcase
    end

`ifndef SYNTH
    // Each result is marked by done for a single cycle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$past(done)) else $error("done held two cycles");
    // Any error status carries a zero value.
    a_zero_on_err: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != npi_pkg::ST_OK) |-> (y_result == 32'sd0))
        else $error("nonzero value with error status");
    // A configuration write while idle drops the built flag.
    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr && state_reg == npi_pkg::S_IDLE) |=> !built_reg)
        else $error("built flag survived register write");
    // A build or evaluate request makes the block busy.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op == npi_pkg::OP_BUILD || op == npi_pkg::OP_EVAL)) |=> busy)
        else $error("request taken without going busy");
`endif

endmodule

// File: dv/tb_newton_piecewise_interpolator_unit.sv
// Self-checking testbench for newton_piecewise_interpolator_unit: point loads,
// coefficient builds and evaluations against a fixed-point scoreboard.
// Depends on npi_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_newton_piecewise_interpolator_unit;

    typedef struct {
        logic [31:0] y;
        logic [1:0]  st;
    } interp_result_t;

    class interp_scoreboard;
        longint px[64];
        longint py[64];
        longint coef[512];
        bit built;
        int unsigned win;
        int unsigned cnt;
        interp_result_t expected_q[$];
        int errors;

        function new();
            for (int i = 0; i < 64; i++)
            begin
                px[i] = 0;
                py[i] = 0;
            end
            for (int i = 0; i < 512; i++)
                coef[i] = 0;
            built = 0;
            win = 3;
            cnt = 0;
            errors = 0;
        endfunction

        function longint sat32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        function int unsigned used();
            return (cnt > 64) ? 64 : cnt;
        endfunction

        function bit window_ok();
            return win >= 2 && win <= 8 && win + 2 <= used();
        endfunction

        function longint fx_div(longint num, longint den);
            if (den == 0)
                return (num > 0) ? 64'sd2147483647 : ((num < 0) ? -64'sd2147483648 : 0);
            return sat32((num * 65536) / den);
        endfunction

        function void build_all();
            longint dd[8];
            int unsigned n;
            n = used();
            for (int k = 0; k + win <= n; k++)
            begin
                for (int i = 0; i < win; i++)
                    dd[i] = py[k + i];
                coef[k * 8] = dd[0];
                for (int j = 1; j < win; j++)
                begin
                    for (int i = 0; i + j < win; i++)
                        dd[i] = fx_div(dd[i + 1] - dd[i], px[k + i + j] - px[k + i]);
                    coef[k * 8 + j] = dd[0];
                end
            end
            built = 1;
        endfunction

        function longint eval_at(longint q);
            int unsigned n;
            int unsigned k;
            int idx;
            longint r;
            longint diff;
            n = used();
            k = 0;
            for (int i = win / 2; i < n; i++)
                if (px[i] < q)
                    k++;
            if (k > n - win)
                k = n - win;
            r = coef[k * 8 + win - 1];
            for (int t = 1; t < win; t++)
            begin
                idx = win - 1 - t;
                diff = sat32(q - px[k + idx]);
                r = sat32(((r * diff) >>> 16) + coef[k * 8 + idx]);
            end
            return r;
        endfunction

        function void write_reg(logic idx, int unsigned val);
            if (idx == npi_pkg::REG_WINDOW_SIZE)
                win = val & 4'hF;
            else
                cnt = val & 7'h7F;
            built = 0;
        endfunction

        function void note_request(npi_pkg::op_t o, logic [5:0] idx,
                                   logic signed [31:0] xv, logic signed [31:0] yv);
            interp_result_t res;
            longint q;
            res.y = '0;
            res.st = npi_pkg::ST_OK;
            q = xv;
            case (o)
                npi_pkg::OP_LOAD:
                begin
                    px[idx] = xv;
                    py[idx] = yv;
                    built = 0;
                    return;
                end
                npi_pkg::OP_NONE:
                    return;
                npi_pkg::OP_BUILD:
                begin
                    if (window_ok())
                        build_all();
                    else
                    begin
                        built = 0;
                        res.st = npi_pkg::ST_BAD_WIN;
                    end
                end
                default:
                begin
                    if (!window_ok())
                        res.st = npi_pkg::ST_BAD_WIN;
                    else if (!built)
                        res.st = npi_pkg::ST_NO_BUILD;
                    else if (q < px[0] || q > px[used() - 1])
                        res.st = npi_pkg::ST_RANGE;
                    else
                        res.y = 32'(eval_at(q));
                end
            endcase
            expected_q = {expected_q, res};
        endfunction

        function void check_result(logic [31:0] y, logic [1:0] st);
            interp_result_t e;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result y=%h status=%0d", y, st);
                return;
            end
            e = expected_q.pop_front();
            if (y !== e.y || st !== e.st)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected y=%h status=%0d, got y=%h status=%0d",
                             e.y, e.st, y, st);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    logic [1:0]  op;
    logic [5:0]  point_index;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
    logic        done;
    logic signed [31:0] y_result;
    logic [1:0]  status;

    interp_scoreboard sb;
    int idle_pct;

    newton_piecewise_interpolator_unit dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy), .op(op), .point_index(point_index),
        .x_value(x_value), .y_value(y_value),
        .done(done), .y_result(y_result), .status(status)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (done === 1'b1)
            sb.check_result(y_result, status);
    end

    task automatic send_req(npi_pkg::op_t o, logic [5:0] idx, logic [31:0] xv,
                            logic [31:0] yv);
        int gap;
        op <= o;
        point_index <= idx;
        x_value <= xv;
        y_value <= yv;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(o, idx, xv, yv);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 5);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Waits until every expected result has come and the block is idle again.
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0 || busy)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic cfg_write(logic idx, int unsigned val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic reload_points(longint spacing);
        longint base;
        longint xv;
        base = -(spacing * 32);
        for (int i = 0; i < 64; i++)
        begin
            xv = base + i * spacing + $urandom_range(0, int'(spacing / 2));
            send_req(npi_pkg::OP_LOAD, i[5:0], xv[31:0], $urandom);
        end
    endtask

    function automatic logic [31:0] pick_query();
        int unsigned n;
        longint lo;
        longint hi;
        longint q;
        n = sb.used();
        if (n == 0 || $urandom_range(0, 99) < 15)
            return $urandom;
        lo = sb.px[0];
        hi = sb.px[n - 1];
        if ($urandom_range(0, 9) == 0)
            return ($urandom_range(0, 1) ? 32'(lo - 1) : 32'(hi + 1));
        if (hi <= lo)
            return lo[31:0];
        q = lo + ({$urandom, $urandom} % (hi - lo + 1));
        return q[31:0];
    endfunction

    task automatic random_item(int build_pct);
        int r;
        int idx;
        longint xv;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            idx = $urandom_range(0, 63);
            if ($urandom_range(0, 6) == 0)
                xv = $signed($urandom);
            else if (idx > 0 && $urandom_range(0, 4) == 0)
                xv = sb.px[idx - 1];
            else if (idx > 0 && idx < 63)
                xv = (sb.px[idx - 1] + sb.px[idx + 1]) / 2;
            else
                xv = sb.px[idx];
            send_req(npi_pkg::OP_LOAD, idx[5:0], xv[31:0], $urandom);
        end
        else if (r < 11)
            send_req(npi_pkg::OP_NONE, 6'($urandom), $urandom, $urandom);
        else if (r < 11 + build_pct)
            send_req(npi_pkg::OP_BUILD, 6'($urandom), $urandom, $urandom);
        else
            send_req(npi_pkg::OP_EVAL, 6'($urandom), pick_query(), $urandom);
    endtask

    initial
    begin
        #50_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int win_tab[15];
        int cnt_tab[15];
        longint spacing_tab[4];
        int modes[3];
        int bpct;
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        start = 1'b0;
        op = npi_pkg::OP_NONE;
        point_index = '0;
        x_value = '0;
        y_value = '0;
        idle_pct = 0;
        win_tab = '{3, 2, 8, 4, 2, 5, 7, 3, 8, 1, 9, 15, 0, 4, 6};
        cnt_tab = '{8, 4, 10, 6, 64, 12, 20, 127, 64, 8, 20, 127, 0, 16, 9};
        spacing_tab = '{64'sd65536, 64'sd16, 64'sd1048576, 64'sd67108864};
        modes = '{0, 81, 33};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part on a window of three over eight points, then a window of seven.
        reload_points(65536);
        wait_idle();
        cfg_write(npi_pkg::REG_POINT_COUNT, 8);
        send_req(npi_pkg::OP_EVAL, 6'd0, 32'(sb.px[0]), 32'd0);
        send_req(npi_pkg::OP_BUILD, 6'd0, 32'd0, 32'd0);
        send_req(npi_pkg::OP_EVAL, 6'd0, 32'(sb.px[0] - 1), 32'd0);
        send_req(npi_pkg::OP_EVAL, 6'd0, 32'(sb.px[7] + 1), 32'd0);
        send_req(npi_pkg::OP_EVAL, 6'd0, 32'(sb.px[0]), 32'd0);
        send_req(npi_pkg::OP_EVAL, 6'd0, 32'(sb.px[7]), 32'd0);
        send_req(npi_pkg::OP_EVAL, 6'd0, 32'((sb.px[3] + sb.px[4]) / 2), 32'd0);
        send_req(npi_pkg::OP_NONE, 6'h3F, 32'hFFFFFFFF, 32'hFFFFFFFF);
        // Zero spacing with the largest and smallest ordinates.
        send_req(npi_pkg::OP_LOAD, 6'd3, 32'(sb.px[2]), 32'h7FFFFFFF);
        send_req(npi_pkg::OP_EVAL, 6'd0, 32'(sb.px[3]), 32'd0);
        send_req(npi_pkg::OP_LOAD, 6'd4, 32'(sb.px[3]), 32'h80000000);
        send_req(npi_pkg::OP_BUILD, 6'd0, 32'd0, 32'd0);
        send_req(npi_pkg::OP_EVAL, 6'd0, 32'(sb.px[3]), 32'd0);
        send_req(npi_pkg::OP_EVAL, 6'd0, 32'(sb.px[2]), 32'd0);
        wait_idle();
        cfg_write(npi_pkg::REG_WINDOW_SIZE, 7);
        send_req(npi_pkg::OP_EVAL, 6'd0, 32'(sb.px[3]), 32'd0);
        send_req(npi_pkg::OP_BUILD, 6'd0, 32'd0, 32'd0);
        wait_idle();

        for (int p = 0; p < 15; p++)
        begin
            idle_pct = modes[p % 3];
            if (p % 2 == 0)
            begin
                reload_points(spacing_tab[(p / 2) % 4]);
                wait_idle();
            end
            cfg_write(npi_pkg::REG_WINDOW_SIZE, win_tab[p]);
            cfg_write(npi_pkg::REG_POINT_COUNT, cnt_tab[p]);
            bpct = (cnt_tab[p] > 16) ? 2 : 8;
            if (win_tab[p] == 8 && cnt_tab[p] == 64)
                bpct = 1;
            send_req(npi_pkg::OP_BUILD, 6'd0, 32'd0, 32'd0);
            for (int i = 0; i < 50; i++)
                random_item(bpct);
            wait_idle();
        end

        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
